>>> rtl/mlmc_pkg.sv
// Package: shared types, constants and the player frame function for the light controller.
package mlmc_pkg;

  localparam int unsigned SONG_COUNT = 4;
  localparam int unsigned SongW      = ($clog2(SONG_COUNT + 1) > 3) ?
                                       $clog2(SONG_COUNT + 1) : 3;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_HOLD_TICKS   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_MOTION_TRACK = 2'd1;

  localparam logic [7:0]  HOLD_TICKS_RST   = 8'd150;
  localparam logic [15:0] MOTION_TRACK_RST = 16'd6;
  localparam logic [7:0]  THRESHOLD_RST    = 8'd50;
  localparam logic [6:0]  LEVEL_FULL       = 7'd100;
  localparam logic [10:0] SAMPLE_FULL      = 11'd1023;

  // Screens
  localparam logic [1:0] SCR_LIGHT  = 2'd0;
  localparam logic [1:0] SCR_THRESH = 2'd1;
  localparam logic [1:0] SCR_MUSIC  = 2'd2;

  // Frame bytes and serializer positions
  localparam logic [7:0] FRM_START = 8'h7E;
  localparam logic [7:0] FRM_VER   = 8'hFF;
  localparam logic [7:0] FRM_LEN   = 8'h06;
  localparam logic [7:0] FRM_CMD   = 8'h03;
  localparam logic [7:0] FRM_ACK   = 8'h00;
  localparam logic [7:0] FRM_END   = 8'hEF;

  localparam logic [3:0] IDX_FIRST  = 4'd0;
  localparam logic [3:0] IDX_STATUS = 4'd8;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_FRAME  = 1'b1;

  typedef struct packed {
    logic       screen_press;
    logic       toggle_press;
    logic       up_press;
    logic       down_press;
    logic       motion_seen;
    logic [9:0] light_sample;
  } in_t;

  // Everything one tick produces: status after the tick plus frame request.
  typedef struct packed {
    logic        lamp_on;
    logic [1:0]  screen;
    logic [6:0]  level_percent;
    logic        manual_mode;
    logic [7:0]  threshold_value;
    logic [2:0]  song_number;
    logic        music_on;
    logic        motion_active;
    logic        send;
    logic [15:0] arg;
  } rec_t;

  function automatic logic [7:0] frame_byte(input logic [3:0] idx, input logic [15:0] arg);
    logic [7:0] b;
    case (idx)
      4'd0:    b = FRM_START;
      4'd1:    b = FRM_VER;
      4'd2:    b = FRM_LEN;
      4'd3:    b = FRM_CMD;
      4'd4:    b = FRM_ACK;
      4'd5:    b = arg[15:8];
      4'd6:    b = arg[7:0];
      4'd7:    b = FRM_END;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

>>> rtl/mlmc_if.sv
// Interfaces: tick input channel and result item output channel.
interface mlmc_in_if;
  logic       valid;
  logic       ready;
  logic       screen_press;
  logic       toggle_press;
  logic       up_press;
  logic       down_press;
  logic       motion_seen;
  logic [9:0] light_sample;

  modport source (output valid, screen_press, toggle_press, up_press, down_press,
                  motion_seen, light_sample, input ready);
  modport sink   (input valid, screen_press, toggle_press, up_press, down_press,
                  motion_seen, light_sample, output ready);
endinterface

interface mlmc_out_if;
  logic       valid;
  logic       ready;
  logic       item_kind;
  logic [7:0] frame_byte;
  logic       last;
  logic       lamp_on;
  logic [1:0] screen;
  logic [6:0] level_percent;
  logic       manual_mode;
  logic [7:0] threshold_value;
  logic [2:0] song_number;
  logic       music_on;
  logic       motion_active;

  modport source (output valid, item_kind, frame_byte, last, lamp_on, screen,
                  level_percent, manual_mode, threshold_value, song_number,
                  music_on, motion_active, input ready);
  modport sink   (input valid, item_kind, frame_byte, last, lamp_on, screen,
                  level_percent, manual_mode, threshold_value, song_number,
                  music_on, motion_active, output ready);
endinterface

>>> rtl/mlmc_step.sv
// Tick state update: screen, mode, lamp, hold, level, threshold, music and song registers.
module mlmc_step (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  mlmc_pkg::in_t       in_i,
  input  logic [7:0]          hold_ticks_i,
  input  logic [15:0]         motion_track_i,
  output mlmc_pkg::rec_t      rec_o
);

  logic [1:0]               screen_q, screen_d;
  logic                     manual_q, manual_d;
  logic                     music_q, music_d;
  logic [7:0]               thresh_q, thresh_d;
  logic [mlmc_pkg::SongW-1:0] song_q, song_d, song_chk, song_up;
  logic [7:0]               hold_q, hold_d, hold_ld;
  logic                     lamp_q, lamp_d;
  logic [6:0]               level_q, level_d;

  logic [16:0] prod;
  logic [6:0]  quo0;
  logic [10:0] rem;
  logic [6:0]  quo;
  logic        trig, send;
  logic [15:0] arg;

  // sample*100/1023: take x>>10, then one correction step
  always_comb begin
    prod = {1'b0, in_i.light_sample, 6'd0} + {2'b0, in_i.light_sample, 5'd0}
         + {5'b0, in_i.light_sample, 2'd0};
    quo0 = prod[16:10];
    rem  = {1'b0, prod[9:0]} + {4'b0, quo0};
    quo  = quo0 + ((rem >= mlmc_pkg::SAMPLE_FULL) ? 7'd1 : 7'd0);
  end

  always_comb begin
    screen_d = screen_q;
    manual_d = manual_q;
    music_d  = music_q;
    thresh_d = thresh_q;
    song_d   = song_q;
    lamp_d   = lamp_q;
    level_d  = level_q;
    hold_ld  = hold_q;
    trig     = 1'b0;
    send     = 1'b0;
    arg      = motion_track_i;
    song_chk = song_q;
    song_up  = song_q;

    if (in_i.screen_press) begin
      screen_d = (screen_q >= mlmc_pkg::SCR_MUSIC) ? mlmc_pkg::SCR_LIGHT : screen_q + 2'd1;
    end

    case (screen_d)
      mlmc_pkg::SCR_LIGHT: begin
        level_d = mlmc_pkg::LEVEL_FULL - quo;
        if (in_i.toggle_press) manual_d = ~manual_q;
        if (in_i.motion_seen && (manual_d || ({1'b0, level_d} <= thresh_q))) begin
          lamp_d  = 1'b1;
          hold_ld = hold_ticks_i;
          trig    = 1'b1;
          send    = 1'b1;
        end else if (hold_q == 8'd0) begin
          lamp_d = 1'b0;
        end
      end
      mlmc_pkg::SCR_THRESH: begin
        thresh_d = thresh_q + {7'd0, in_i.up_press} - {7'd0, in_i.down_press};
      end
      default: begin
        if (in_i.toggle_press) music_d = ~music_q;
        if (music_d) begin
          if (song_q < mlmc_pkg::SongW'(1) || song_q > mlmc_pkg::SongW'(mlmc_pkg::SONG_COUNT))
            song_chk = mlmc_pkg::SongW'(1);
          song_up = song_chk;
          if (in_i.up_press)
            song_up = (song_chk == mlmc_pkg::SongW'(mlmc_pkg::SONG_COUNT)) ?
                      mlmc_pkg::SongW'(1) : song_chk + mlmc_pkg::SongW'(1);
          song_d = song_up;
          if (in_i.down_press)
            song_d = (song_up == mlmc_pkg::SongW'(1)) ?
                     mlmc_pkg::SongW'(mlmc_pkg::SONG_COUNT) : song_up - mlmc_pkg::SongW'(1);
          send = 1'b1;
          arg  = 16'(song_d);
        end
      end
    endcase

    hold_d = (hold_ld == 8'd0) ? 8'd0 : hold_ld - 8'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_q <= mlmc_pkg::SCR_LIGHT;
      manual_q <= 1'b0;
      music_q  <= 1'b0;
      thresh_q <= mlmc_pkg::THRESHOLD_RST;
      song_q   <= mlmc_pkg::SongW'(1);
      hold_q   <= 8'd0;
      lamp_q   <= 1'b0;
      level_q  <= 7'd0;
    end else if (fire_i) begin
      screen_q <= screen_d;
      manual_q <= manual_d;
      music_q  <= music_d;
      thresh_q <= thresh_d;
      song_q   <= song_d;
      hold_q   <= hold_d;
      lamp_q   <= lamp_d;
      level_q  <= level_d;
    end
  end

  always_comb begin
    rec_o.lamp_on         = lamp_d;
    rec_o.screen          = screen_d;
    rec_o.level_percent   = level_d;
    rec_o.manual_mode     = manual_d;
    rec_o.threshold_value = thresh_d;
    rec_o.song_number     = song_d[2:0];
    rec_o.music_on        = music_d;
    rec_o.motion_active   = trig;
    rec_o.send            = send;
    rec_o.arg             = arg;
  end

endmodule

>>> rtl/mlmc_emit.sv
// Result serializer: eight frame bytes when requested, then the closing status item.
module mlmc_emit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  mlmc_pkg::rec_t  rec_i,
  output logic            take_o,
  mlmc_out_if.source      out_o
);

  logic           valid_q;
  logic [3:0]     idx_q;
  mlmc_pkg::rec_t rec_q;
  logic           fire, at_status;

  assign fire      = valid_q && out_o.ready;
  assign at_status = (idx_q == mlmc_pkg::IDX_STATUS);
  assign take_o    = !valid_q || (fire && at_status);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= mlmc_pkg::IDX_STATUS;
    end else if (load_i) begin
      valid_q <= 1'b1;
      idx_q   <= rec_i.send ? mlmc_pkg::IDX_FIRST : mlmc_pkg::IDX_STATUS;
    end else if (fire) begin
      if (at_status) valid_q <= 1'b0;
      else           idx_q   <= idx_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) rec_q <= rec_i;
  end

  always_comb begin
    out_o.valid           = valid_q;
    out_o.item_kind       = at_status ? mlmc_pkg::KIND_STATUS : mlmc_pkg::KIND_FRAME;
    out_o.frame_byte      = mlmc_pkg::frame_byte(idx_q, rec_q.arg);
    out_o.last            = at_status;
    out_o.lamp_on         = rec_q.lamp_on;
    out_o.screen          = rec_q.screen;
    out_o.level_percent   = rec_q.level_percent;
    out_o.manual_mode     = rec_q.manual_mode;
    out_o.threshold_value = rec_q.threshold_value;
    out_o.song_number     = rec_q.song_number;
    out_o.music_on        = rec_q.music_on;
    out_o.motion_active   = rec_q.motion_active;
  end

endmodule

>>> rtl/motion_light_mode_controller.sv
// Top level: motion light mode controller with input register, tick buffer and serializer.
//
// Usage:
//   in_i   carries one 100 ms tick per item: button presses, a motion flag and a
//          10-bit light sample. Taken when valid and ready are both high.
//   out_o  returns the items of each tick: eight player frame bytes
//          (7E FF 06 03 00 hi lo EF) when the tick sends a frame, then one
//          status item with last set. Every item carries the state after the tick.
//   cfg    cfg_we_i writes cfg_data_i into register cfg_idx_i on the clock edge:
//          index 0 hold_ticks, index 1 motion_track; other indexes are ignored.
// Path: an accepted item is registered in the input register, updated in one pass
//   into the tick buffer, then loaded into the serializer, which shows its first result.
// Throughput: the serializer sends one result per cycle while out_o.ready is high,
//   so a tick gives nine items with a frame and one without; the input register
//   and tick buffer keep two further ticks queued while the serializer works.
// Reset (rst_ni low, asynchronous): screen 0, auto mode, music off, threshold 50,
//   song 1, lamp off, level 0, hold_ticks 150, motion_track 6; all stages empty.
// Stall: when out_o.ready is low the current item holds; the buffer and input
//   register fill, then in_i.ready drops until the receiver drains.
module motion_light_mode_controller (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  mlmc_in_if.sink                       in_i,
  mlmc_out_if.source                    out_o,
  input  logic                          cfg_we_i,
  input  logic [mlmc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mlmc_pkg::CfgDataW-1:0] cfg_data_i
);

  // Configuration registers
  logic [7:0]  hold_ticks_q;
  logic [15:0] motion_track_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_ticks_q   <= mlmc_pkg::HOLD_TICKS_RST;
      motion_track_q <= mlmc_pkg::MOTION_TRACK_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mlmc_pkg::REG_HOLD_TICKS:   hold_ticks_q   <= cfg_data_i[7:0];
        mlmc_pkg::REG_MOTION_TRACK: motion_track_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage handshakes: input register -> state update -> tick buffer -> serializer
  logic           in_valid_q;
  mlmc_pkg::in_t  in_q;
  logic           rec_valid_q;
  mlmc_pkg::rec_t rec_q;
  mlmc_pkg::rec_t step_rec;
  logic           step_fire, xfer, emit_take, in_fire;

  assign xfer      = rec_valid_q && emit_take;
  assign step_fire = in_valid_q && (!rec_valid_q || xfer);
  assign in_i.ready = !in_valid_q || step_fire;
  assign in_fire   = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      rec_valid_q <= 1'b0;
    end else begin
      if (in_fire)        in_valid_q <= 1'b1;
      else if (step_fire) in_valid_q <= 1'b0;
      if (step_fire)      rec_valid_q <= 1'b1;
      else if (xfer)      rec_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q.screen_press <= in_i.screen_press;
      in_q.toggle_press <= in_i.toggle_press;
      in_q.up_press     <= in_i.up_press;
      in_q.down_press   <= in_i.down_press;
      in_q.motion_seen  <= in_i.motion_seen;
      in_q.light_sample <= in_i.light_sample;
    end
    if (step_fire) rec_q <= step_rec;
  end

  mlmc_step u_step (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (step_fire),
    .in_i           (in_q),
    .hold_ticks_i   (hold_ticks_q),
    .motion_track_i (motion_track_q),
    .rec_o          (step_rec)
  );

  mlmc_emit u_emit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (xfer),
    .rec_i  (rec_q),
    .take_o (emit_take),
    .out_o  (out_o)
  );

`ifndef SYNTH
  // A ready tick buffer is never overwritten before the serializer takes it.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_fire |-> (!rec_valid_q || xfer))
    else $error("tick buffer overwritten");

  // The closing item of a tick is always a status item.
  a_last_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.last) |-> (out_o.item_kind == mlmc_pkg::KIND_STATUS))
    else $error("last item is not a status item");

  // Screen stays in its three values.
  a_screen_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.screen != 2'd3))
    else $error("screen out of range");

  // An accepted tick is held in the input register next cycle.
  a_in_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> in_valid_q)
    else $error("accepted tick lost");

  // A buffered tick reaches the serializer once it finishes its current tick.
  a_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rec_valid_q && !out_o.valid) |-> xfer)
    else $error("serializer idle with tick waiting");
`endif

endmodule

>>> sim/motion_light_mode_controller_checker.sv
// Checker: watches the tick and result channels, predicts every result item and compares.
module motion_light_mode_controller_checker
  import mlmc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  mlmc_in_if                  tick_i,
  mlmc_out_if                 item_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  fail_cnt_o,
  output int                  pending_o
);

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       last;
    logic       lamp;
    logic [1:0] screen;
    logic [6:0] level;
    logic       manual;
    logic [7:0] thresh;
    logic [2:0] song;
    logic       music;
    logic       trig;
  } result_t;

  // register copies
  logic [7:0]  hold_cfg;
  logic [15:0] track_cfg;

  // controller state copy
  logic [1:0] screen_q;
  logic       manual_q;
  logic       music_q;
  logic       lamp_q;
  logic [7:0] thresh_q;
  logic [7:0] hold_left;
  logic [6:0] level_q;
  int         song_q;

  result_t tick_items_q[$];

  task automatic clear_controller();
    hold_cfg  = HOLD_TICKS_RST;
    track_cfg = MOTION_TRACK_RST;
    screen_q  = SCR_LIGHT;
    manual_q  = 1'b0;
    music_q   = 1'b0;
    lamp_q    = 1'b0;
    thresh_q  = THRESHOLD_RST;
    hold_left = '0;
    level_q   = '0;
    song_q    = 1;
    tick_items_q.delete();
  endtask

  // One tick: update the state copy and queue the frame bytes and status item.
  task automatic step_controller(input in_t t);
    logic        send;
    logic        trig;
    logic [15:0] arg;
    logic [7:0]  frm [8];
    result_t     r;
    send = 1'b0;
    trig = 1'b0;
    arg  = '0;
    if (t.screen_press) screen_q = (screen_q >= SCR_MUSIC) ? SCR_LIGHT : screen_q + 2'd1;
    if (screen_q == SCR_LIGHT) begin
      level_q = 7'(int'(LEVEL_FULL) -
                   (int'(t.light_sample) * int'(LEVEL_FULL)) / int'(SAMPLE_FULL));
      if (t.toggle_press) manual_q = ~manual_q;
      if (t.motion_seen && (manual_q || {1'b0, level_q} <= thresh_q)) begin
        lamp_q    = 1'b1;
        hold_left = hold_cfg;
        send      = 1'b1;
        arg       = track_cfg;
        trig      = 1'b1;
      end else if (hold_left == 0) begin
        lamp_q = 1'b0;
      end
    end else if (screen_q == SCR_THRESH) begin
      if (t.up_press) thresh_q = thresh_q + 8'd1;
      if (t.down_press) thresh_q = thresh_q - 8'd1;
    end else begin
      if (t.toggle_press) music_q = ~music_q;
      if (music_q) begin
        if (song_q < 1 || song_q > int'(SONG_COUNT)) song_q = 1;
        if (t.up_press) song_q = (song_q % int'(SONG_COUNT)) + 1;
        if (t.down_press) song_q = (song_q == 1) ? int'(SONG_COUNT) : song_q - 1;
        send = 1'b1;
        arg  = 16'(song_q);
      end
    end
    if (hold_left != 0) hold_left = hold_left - 8'd1;

    r.lamp   = lamp_q;
    r.screen = screen_q;
    r.level  = level_q;
    r.manual = manual_q;
    r.thresh = thresh_q;
    r.song   = 3'(song_q);
    r.music  = music_q;
    r.trig   = trig;
    if (send) begin
      frm = '{FRM_START, FRM_VER, FRM_LEN, FRM_CMD, FRM_ACK, arg[15:8], arg[7:0], FRM_END};
      for (int i = 0; i < 8; i++) begin
        r.kind = KIND_FRAME;
        r.data = frm[i];
        r.last = 1'b0;
        tick_items_q.push_back(r);
      end
    end
    r.kind = KIND_STATUS;
    r.data = '0;
    r.last = 1'b1;
    tick_items_q.push_back(r);
  endtask

  task automatic note_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      fail_cnt_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    in_t     t;
    result_t head;
    if (!rst_ni) begin
      clear_controller();
      fail_cnt_o = 0;
      pending_o  = 0;
    end else begin
      if (item_i.valid && item_i.ready) begin
        if (tick_items_q.size() == 0) begin
          $display("%0t: result item with nothing expected, expected none actual kind %0h",
                   $time, item_i.item_kind);
          fail_cnt_o++;
        end else begin
          head = tick_items_q.pop_front();
          note_field("item_kind", head.kind, item_i.item_kind);
          note_field("frame_byte", head.data, item_i.frame_byte);
          note_field("last", head.last, item_i.last);
          note_field("lamp_on", head.lamp, item_i.lamp_on);
          note_field("screen", head.screen, item_i.screen);
          note_field("level_percent", head.level, item_i.level_percent);
          note_field("manual_mode", head.manual, item_i.manual_mode);
          note_field("threshold_value", head.thresh, item_i.threshold_value);
          note_field("song_number", head.song, item_i.song_number);
          note_field("music_on", head.music, item_i.music_on);
          note_field("motion_active", head.trig, item_i.motion_active);
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_HOLD_TICKS) hold_cfg = cfg_data_i[7:0];
        else if (cfg_idx_i == REG_MOTION_TRACK) track_cfg = cfg_data_i;
      end
      if (tick_i.valid && tick_i.ready) begin
        t.screen_press = tick_i.screen_press;
        t.toggle_press = tick_i.toggle_press;
        t.up_press     = tick_i.up_press;
        t.down_press   = tick_i.down_press;
        t.motion_seen  = tick_i.motion_seen;
        t.light_sample = tick_i.light_sample;
        step_controller(t);
      end
      pending_o = tick_items_q.size();
    end
  end

endmodule

>>> sim/motion_light_mode_controller_test.sv
// Testbench top: drives ticks and register writes into the light controller and gives the verdict.
module motion_light_mode_controller_test;
  import mlmc_pkg::*;

  // Indexes that map to no register; writes there must change nothing.
  localparam logic [CfgIdxW-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_SPARE_B = 2'd3;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  int fail_cnt;
  int pending;   // result items predicted but not yet seen

  // Stimulus-side bookkeeping: which screen the block is on (to steer
  // threshold ramps) and the ramp in progress.
  logic [1:0] scr_now;
  int         ramp_left;
  logic       ramp_up;

  // Receiver stall pattern: a fresh 32-bit mask each time the 5-bit beat counter wraps.
  logic [31:0] stall_pat;
  logic [4:0]  beat;

  mlmc_in_if  tick_ch ();
  mlmc_out_if item_ch ();

  motion_light_mode_controller dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (tick_ch),
    .out_o      (item_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  motion_light_mode_controller_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tick_i     (tick_ch),
    .item_i     (item_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Receiver: mix of always-ready, light, medium and heavy stalling.
  always @(negedge clk_i) begin
    if (beat == 0) begin
      case ($urandom_range(0, 3))
        0:       stall_pat = '1;
        1:       stall_pat = $urandom | $urandom;
        2:       stall_pat = $urandom;
        default: stall_pat = $urandom & $urandom;
      endcase
    end
    item_ch.ready = stall_pat[beat];
    beat = beat + 5'd1;
  end

  // Present one tick at the falling edge and hold it until accepted.
  // Leaves valid high; the caller lowers it when a gap follows.
  task automatic send_tick(input in_t t);
    tick_ch.valid        = 1'b1;
    tick_ch.screen_press = t.screen_press;
    tick_ch.toggle_press = t.toggle_press;
    tick_ch.up_press     = t.up_press;
    tick_ch.down_press   = t.down_press;
    tick_ch.motion_seen  = t.motion_seen;
    tick_ch.light_sample = t.light_sample;
    do @(posedge clk_i); while (!tick_ch.ready);
    @(negedge clk_i);
    if (t.screen_press) scr_now = (scr_now == SCR_MUSIC) ? SCR_LIGHT : scr_now + 2'd1;
  endtask

  task automatic tick(input logic sp, input logic tg, input logic up, input logic dn,
                      input logic mo, input logic [9:0] smp);
    in_t t;
    t.screen_press = sp;
    t.toggle_press = tg;
    t.up_press     = up;
    t.down_press   = dn;
    t.motion_seen  = mo;
    t.light_sample = smp;
    send_tick(t);
  endtask

  // Stop sending and wait until every predicted item has come out.
  task automatic drain();
    tick_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // Register write; only called with the block drained.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
  endtask

  // Next random tick. On the threshold screen it sometimes starts a long
  // run of up or down presses so the threshold can wander far and wrap.
  task automatic next_random(output in_t t);
    t = '0;
    if (ramp_left == 0 && scr_now == SCR_THRESH && $urandom_range(0, 19) == 0) begin
      ramp_left = $urandom_range(10, 60);
      ramp_up   = ($urandom_range(0, 2) == 0);
    end
    t.motion_seen = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 5))
      0:       t.light_sample = '0;
      1:       t.light_sample = '1;
      default: t.light_sample = 10'($urandom);
    endcase
    if (ramp_left > 0) begin
      ramp_left--;
      t.up_press   = ramp_up;
      t.down_press = !ramp_up;
    end else begin
      t.screen_press = ($urandom_range(0, 5) == 0);
      t.toggle_press = ($urandom_range(0, 3) == 0);
      t.up_press     = ($urandom_range(0, 2) == 0);
      t.down_press   = ($urandom_range(0, 2) == 0);
    end
  endtask

  // Bursts of back-to-back ticks; unless steady, random gaps between bursts
  // and now and then a full drain before going on.
  task automatic run_random(input int n, input bit steady);
    int  burst;
    in_t t;
    while (n > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && n > 0) begin
        next_random(t);
        send_tick(t);
        burst--;
        n--;
      end
      if (!steady) begin
        tick_ch.valid = 1'b0;
        if ($urandom_range(0, 9) == 0) drain();
        else repeat ($urandom_range(1, 6)) @(negedge clk_i);
      end
    end
  endtask

  initial begin
    clk_i                = 1'b0;
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_idx_i            = '0;
    cfg_data_i           = '0;
    tick_ch.valid        = 1'b0;
    tick_ch.screen_press = 1'b0;
    tick_ch.toggle_press = 1'b0;
    tick_ch.up_press     = 1'b0;
    tick_ch.down_press   = 1'b0;
    tick_ch.motion_seen  = 1'b0;
    tick_ch.light_sample = '0;
    item_ch.ready        = 1'b0;
    stall_pat            = '1;
    beat                 = '0;
    scr_now              = SCR_LIGHT;
    ramp_left            = 0;
    ramp_up              = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed, reset register values (hold 150, track 6).
    // Lighting screen: bright and dark samples, hold, manual mode.
    tick(0, 0, 0, 0, 1, 10'd0);      // level 100, above threshold: no trigger
    tick(0, 0, 0, 0, 1, 10'd1023);   // level 0: trigger, frame for track 6
    tick(0, 0, 0, 0, 0, 10'd512);    // no motion, hold keeps lamp lit
    tick(0, 1, 0, 0, 1, 10'd0);      // manual on: bright room still triggers
    tick(0, 1, 0, 0, 0, 10'd700);    // back to auto
    // Threshold screen: steps, both buttons cancel, motion ignored.
    tick(1, 0, 1, 0, 1, 10'd1023);
    tick(0, 0, 0, 1, 0, 10'd0);
    tick(0, 0, 1, 1, 0, 10'd0);
    tick(0, 0, 1, 0, 0, 10'd1023);
    // Music screen: song wraps both ways, both buttons, music off.
    tick(1, 1, 0, 0, 0, 10'd0);      // music on: frame for song 1
    tick(0, 0, 1, 0, 0, 10'd0);
    tick(0, 0, 0, 1, 0, 10'd0);
    tick(0, 0, 0, 1, 0, 10'd0);      // 1 wraps to the top song
    tick(0, 0, 1, 0, 0, 10'd0);      // top song wraps to 1
    tick(0, 0, 1, 1, 1, 10'd1023);   // up then down
    tick(0, 1, 0, 0, 0, 10'd0);      // music off: status only
    tick(0, 0, 1, 0, 0, 10'd0);      // buttons ignored with music off
    // Back on the lighting screen, level right around the threshold.
    tick(1, 0, 0, 0, 1, 10'd1023);
    tick(0, 0, 0, 0, 1, 10'd492);    // level one above threshold
    tick(0, 0, 0, 0, 1, 10'd511);    // level equal to threshold: triggers
    tick(0, 0, 0, 0, 1, 10'd522);    // level below threshold
    tick(1, 0, 0, 0, 0, 10'd0);      // lamp never turned off off-screen
    tick(1, 1, 0, 0, 0, 10'd0);
    tick(1, 0, 0, 0, 0, 10'd0);

    // Threshold sweep from the known value 51: down through zero, then
    // back up across the wrap point.
    while (scr_now != SCR_THRESH) tick(1, 0, 0, 0, 0, 10'd0);
    repeat (53) tick(0, 0, 0, 1, 1'($urandom_range(0, 1)), 10'($urandom));
    repeat (3) tick(0, 0, 1, 0, 1'($urandom_range(0, 1)), 10'($urandom));
    run_random(30, 1'b0);

    // Zero hold: lamp stays lit until a later non-triggering tick.
    drain();
    write_reg(REG_HOLD_TICKS, 16'd0);
    write_reg(REG_MOTION_TRACK, 16'hFFFF);
    run_random(30, 1'b0);

    // Longest hold, track 0, sender never idles.
    drain();
    write_reg(REG_HOLD_TICKS, 16'd255);
    write_reg(REG_MOTION_TRACK, 16'h0000);
    run_random(30, 1'b1);

    // Writes to unused indexes must not disturb anything.
    drain();
    write_reg(REG_HOLD_TICKS, 16'd1);
    write_reg(REG_SPARE_A, 16'($urandom));
    write_reg(REG_SPARE_B, 16'($urandom));
    write_reg(REG_MOTION_TRACK, 16'($urandom));
    run_random(30, 1'b0);

    drain();
    write_reg(REG_HOLD_TICKS, 16'($urandom_range(2, 20)));
    write_reg(REG_MOTION_TRACK, 16'($urandom));
    run_random(30, 1'b0);

    drain();
    repeat (8) @(negedge clk_i);
    if (fail_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> filelist.f
rtl/mlmc_pkg.sv
rtl/mlmc_if.sv
rtl/mlmc_step.sv
rtl/mlmc_emit.sv
rtl/motion_light_mode_controller.sv
sim/motion_light_mode_controller_checker.sv
sim/motion_light_mode_controller_test.sv
